/* sv/lidar_angle_bin_averager_unit_macros.svh */
// Assertion macros for the lidar angle-bin averager.
`ifndef LIDAR_ANGLE_BIN_AVERAGER_UNIT_MACROS_SVH
`define LIDAR_ANGLE_BIN_AVERAGER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LBAVG_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LBAVG_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lbavg_pkg.sv */
// Shared constants and types for the lidar angle-bin averager.
`default_nettype none

package lbavg_pkg;

  localparam int BIN_COUNT         = 360;
  localparam int BIN_W             = 9;
  localparam int DIST_BITS_DEFAULT = 16;

  localparam int OP_W      = 2;
  localparam int ANGLE_W   = 16;
  localparam int DIST_Q2_W = 18;
  localparam int QUAL_W    = 8;
  localparam int AVG_W     = 20;
  localparam int SCAN_W    = 8;
  localparam int EPOCH_W   = 8;

  localparam int ANGLE_MULT  = 90;
  localparam int ANGLE_MUL_W = 7;
  localparam int ANGLE_SHIFT = 14;
  localparam int Q2_SHIFT    = 2;
  localparam int FRAC_BITS   = 4;

  localparam int QUALITY_RESET = 60;
  localparam int SCANS_RESET   = 1;
  localparam logic [AVG_W-1:0] AVG_MAX = '1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_NODE      = 2'd0,
    OP_END_SCAN  = 2'd1,
    OP_READ      = 2'd2,
    OP_NEW_ROUND = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NODE,
    ST_FETCH,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic {
    REG_QUALITY = 1'b0,
    REG_SCANS   = 1'b1
  } reg_idx_t;

endpackage

`default_nettype wire

/* sv/lidar_angle_bin_averager_unit.sv */
// Lidar angle-bin averager: 360-bin distance table with per-scan capture and averaging.
// Order: a node reads its bin entry, then writes it back; end of scan and new round
//   update the scan count and round tag on acceptance; a bin read fetches, divides, then outputs.
// Throughput: one transaction at a time; a node needs a read and a write-back of its
//   bin table entry; a bin read is bound by the bit-serial divider.
// Reset: synchronous, active low; then a pass clears all 360 bins with in_tready low,
//   and the same pass repeats once every 255 new rounds when the round tag wraps.
`default_nettype none

`include "lidar_angle_bin_averager_unit_macros.svh"

module lidar_angle_bin_averager_unit #(
  parameter int DISTANCE_BITS = lbavg_pkg::DIST_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: angle_q14[15:0], distance_q2[33:16], quality[41:34], read_bin[50:42]
  input  logic [lbavg_pkg::IN_DATA_W-1:0]   in_tdata,
  // tuser: opcode[1:0]
  input  logic [lbavg_pkg::OP_W-1:0]        in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: bin_number[8:0], average_mm_q4[28:9]
  output logic [lbavg_pkg::OUT_DATA_W-1:0]  out_tdata,
  // tuser: average_valid[0]
  output logic                              out_tuser,
  // configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lbavg_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [lbavg_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [lbavg_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready
);

  import lbavg_pkg::*;

  // Table entry layout, lowest bits first: sum, count, pending value,
  // pending valid, scan tag of the pending value, round epoch.
  localparam int SUM_W    = DISTANCE_BITS + SCAN_W;
  localparam int CNT_W    = SCAN_W;
  localparam int CNT_LO   = SUM_W;
  localparam int PEND_LO  = CNT_LO + CNT_W;
  localparam int PV_BIT   = PEND_LO + DISTANCE_BITS;
  localparam int SCAN_LO  = PV_BIT + 1;
  localparam int EPOCH_LO = SCAN_LO + SCAN_W;
  localparam int ENTRY_W  = EPOCH_LO + EPOCH_W;

  // Divider: dividend is sum with four fraction bits, one quotient bit a cycle.
  localparam int QW     = SUM_W + FRAC_BITS;
  localparam int REM_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(QW + 1);

  localparam int MM_W   = DIST_Q2_W - Q2_SHIFT;
  localparam int WIDE_W = (DISTANCE_BITS > MM_W) ? DISTANCE_BITS : MM_W;
  localparam int PROD_W = ANGLE_W + ANGLE_MUL_W;

  // Input field offsets in tdata.
  localparam int ANGLE_LO = 0;
  localparam int DIST_LO  = ANGLE_LO + ANGLE_W;
  localparam int QUAL_LO  = DIST_LO + DIST_Q2_W;
  localparam int RBIN_LO  = QUAL_LO + QUAL_W;

  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  state_t                   state_r, state_nxt;
  logic [QUAL_W-1:0]        thr_r;
  logic [SCAN_W-1:0]        sta_r;
  logic [SCAN_W-1:0]        scans_done_r;
  logic [EPOCH_W-1:0]       epoch_r;
  logic [BIN_W-1:0]         clr_idx_r;

  logic [BIN_W-1:0]         rec_bin_r;
  logic                     rec_oob_r;
  logic [DISTANCE_BITS-1:0] rec_mm_r;

  logic [ENTRY_W-1:0]       bin_mem [BIN_COUNT];
  logic [ENTRY_W-1:0]       mem_q_r;

  logic [QW-1:0]            div_dq_r;
  logic [REM_W-1:0]         div_rem_r;
  logic [CNT_W-1:0]         div_cnt_r;
  logic [STEP_W-1:0]        div_step_r;
  logic                     res_ok_r;

  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic                     out_user_r;

  // ---------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------
  op_t                 in_op;
  logic [ANGLE_W-1:0]  in_angle;
  logic [DIST_Q2_W-1:0] in_dist;
  logic [QUAL_W-1:0]   in_quality;
  logic [BIN_W-1:0]    in_rbin;
  logic                in_accept;
  logic                in_rbin_oob;
  logic [PROD_W-1:0]   angle_prod;
  logic [BIN_W-1:0]    node_bin;
  logic [MM_W-1:0]     mm_raw;
  logic [WIDE_W-1:0]   mm_wide;
  logic [WIDE_W-1:0]   mm_cap;
  logic [WIDE_W-1:0]   mm_sat;
  logic [DISTANCE_BITS-1:0] node_mm;
  logic [SCAN_W-1:0]   scans_need;
  logic                round_complete;
  logic                take_node;
  logic                start_read;
  logic                rd_en;
  logic [BIN_W-1:0]    rd_addr;

  assign in_op      = op_t'(in_tuser);
  assign in_angle   = in_tdata[ANGLE_LO +: ANGLE_W];
  assign in_dist    = in_tdata[DIST_LO +: DIST_Q2_W];
  assign in_quality = in_tdata[QUAL_LO +: QUAL_W];
  assign in_rbin    = in_tdata[RBIN_LO +: BIN_W];

  assign in_tready   = (state_r == ST_IDLE);
  assign in_accept   = in_tvalid && in_tready;
  assign in_rbin_oob = (in_rbin >= BIN_W'(BIN_COUNT));

  // Bin is floor(angle * 90 / 2^14); always below 360 for a 16-bit angle.
  assign angle_prod = PROD_W'(in_angle) * PROD_W'(ANGLE_MULT);
  assign node_bin   = BIN_W'(angle_prod >> ANGLE_SHIFT);

  // Quarter millimeters to millimeters, saturated to the table's distance width.
  assign mm_raw  = in_dist[DIST_Q2_W-1:Q2_SHIFT];
  assign mm_wide = WIDE_W'(mm_raw);
  assign mm_cap  = WIDE_W'((64'd1 << DISTANCE_BITS) - 64'd1);
  assign mm_sat  = (mm_wide > mm_cap) ? mm_cap : mm_wide;
  assign node_mm = mm_sat[DISTANCE_BITS-1:0];

  // A scan count of zero behaves as one.
  assign scans_need     = (sta_r == '0) ? SCAN_W'(1) : sta_r;
  assign round_complete = (scans_done_r >= scans_need);

  assign take_node  = in_accept && (in_op == OP_NODE) && !round_complete &&
                      (in_quality >= thr_r);
  assign start_read = in_accept && (in_op == OP_READ);
  assign rd_en      = take_node || start_read;
  assign rd_addr    = take_node ? node_bin : (in_rbin_oob ? '0 : in_rbin);

  // ---------------------------------------------------------------------
  // Effective entry: stale rounds read as empty, and a pending value from a
  // scan that has since ended is folded into sum and count on the fly.
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0]         q_sum;
  logic [CNT_W-1:0]         q_cnt;
  logic [DISTANCE_BITS-1:0] q_pend;
  logic                     q_pv;
  logic [SCAN_W-1:0]        q_scan;
  logic [EPOCH_W-1:0]       q_epoch;
  logic                     q_live;
  logic                     q_commit;
  logic [SUM_W-1:0]         sum_c;
  logic [CNT_W-1:0]         cnt_c;

  assign q_sum   = mem_q_r[0 +: SUM_W];
  assign q_cnt   = mem_q_r[CNT_LO +: CNT_W];
  assign q_pend  = mem_q_r[PEND_LO +: DISTANCE_BITS];
  assign q_pv    = mem_q_r[PV_BIT];
  assign q_scan  = mem_q_r[SCAN_LO +: SCAN_W];
  assign q_epoch = mem_q_r[EPOCH_LO +: EPOCH_W];

  assign q_live   = (q_epoch == epoch_r);
  assign q_commit = q_live && q_pv && (q_scan != scans_done_r);
  assign sum_c    = (q_live ? q_sum : '0) + (q_commit ? SUM_W'(q_pend) : '0);
  assign cnt_c    = (q_live ? q_cnt : '0) + CNT_W'(q_commit);

  // ---------------------------------------------------------------------
  // Bin table memory: one write port, one registered read port
  // ---------------------------------------------------------------------
  logic               mem_we;
  logic [BIN_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  assign mem_we    = (state_r == ST_CLEAR) || (state_r == ST_NODE);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_idx_r : rec_bin_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 :
                     {epoch_r, scans_done_r, 1'b1, rec_mm_r, cnt_c, sum_c};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      mem_q_r <= bin_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Divider step
  // ---------------------------------------------------------------------
  logic [REM_W-1:0] rem_sh;
  logic             rem_ge;
  logic [REM_W-1:0] rem_new;
  logic             div_last;
  logic             fetch_ok;
  logic             out_load;
  logic [AVG_W-1:0] avg_val;

  assign rem_sh   = {div_rem_r[REM_W-2:0], div_dq_r[QW-1]};
  assign rem_ge   = (rem_sh >= REM_W'(div_cnt_r));
  assign rem_new  = rem_ge ? (rem_sh - REM_W'(div_cnt_r)) : rem_sh;
  assign div_last = (div_step_r == STEP_W'(QW - 1));
  assign fetch_ok = !rec_oob_r && (cnt_c != '0) && (sum_c != '0);

  // Saturate the quotient to the output width.
  assign avg_val  = (|div_dq_r[QW-1:AVG_W]) ? AVG_MAX : div_dq_r[AVG_W-1:0];
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        // sweep every bin back to empty
        if (clr_idx_r == BIN_W'(BIN_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take_node) begin
          state_nxt = ST_NODE;
        end else if (start_read) begin
          state_nxt = ST_FETCH;
        end else if (in_accept && (in_op == OP_NEW_ROUND) && (epoch_r == EPOCH_LAST)) begin
          // epoch wraps: wipe stale tags before reuse
          state_nxt = ST_CLEAR;
        end
      end
      ST_NODE: begin
        state_nxt = ST_IDLE;
      end
      ST_FETCH: begin
        state_nxt = fetch_ok ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (div_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_idx_r    <= '0;
      scans_done_r <= '0;
      epoch_r      <= EPOCH_FIRST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == ST_CLEAR) begin
        clr_idx_r <= (clr_idx_r == BIN_W'(BIN_COUNT - 1)) ? '0 : clr_idx_r + 1'b1;
      end

      if (in_accept && (in_op == OP_END_SCAN) && !round_complete) begin
        scans_done_r <= scans_done_r + 1'b1;
      end else if (in_accept && (in_op == OP_NEW_ROUND)) begin
        scans_done_r <= '0;
        epoch_r      <= (epoch_r == EPOCH_LAST) ? EPOCH_FIRST : epoch_r + 1'b1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: captured transaction, divider and output data
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rec_bin_r <= take_node ? node_bin : in_rbin;
      rec_oob_r <= in_rbin_oob;
      rec_mm_r  <= node_mm;
    end

    if (state_r == ST_FETCH) begin
      div_dq_r   <= fetch_ok ? {sum_c, FRAC_BITS'(0)} : '0;
      div_rem_r  <= '0;
      div_cnt_r  <= cnt_c;
      div_step_r <= '0;
      res_ok_r   <= fetch_ok;
    end else if (state_r == ST_DIV) begin
      div_dq_r   <= {div_dq_r[QW-2:0], rem_ge};
      div_rem_r  <= rem_new;
      div_step_r <= div_step_r + 1'b1;
    end

    if (out_load) begin
      out_data_r <= OUT_DATA_W'({avg_val, rec_bin_r});
      out_user_r <= res_ok_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= QUAL_W'(QUALITY_RESET);
      sta_r <= SCAN_W'(SCANS_RESET);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_QUALITY: thr_r <= cfg_pwdata[QUAL_W-1:0];
        REG_SCANS:   sta_r <= cfg_pwdata[SCAN_W-1:0];
        default:     thr_r <= thr_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_QUALITY: cfg_prdata = CFG_DATA_W'(thr_r);
      REG_SCANS:   cfg_prdata = CFG_DATA_W'(sta_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `LBAVG_ASSERT_SAME(a_no_write_on_accept, clk, rst_n, mem_we, !in_accept, "table write overlaps accept")
  `LBAVG_ASSERT_SAME(a_epoch_nonzero, clk, rst_n, state_r != ST_CLEAR, epoch_r != '0, "epoch collides with cleared tag")
  `LBAVG_ASSERT_SAME(a_node_bin_range, clk, rst_n, state_r == ST_NODE, rec_bin_r < BIN_W'(BIN_COUNT), "node bin out of range")
  `LBAVG_ASSERT_NEXT(a_result_loaded, clk, rst_n, out_load, out_tvalid && (state_r == ST_IDLE), "result not presented")

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the lidar angle-bin averager: directed table, then phased random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lbavg_pkg::*;

  localparam int DIST_BITS = DIST_BITS_DEFAULT;
  // Worst correct run is far below this; covers divider latency, stalls and clearing passes.
  localparam int CYCLE_LIMIT = 800000;
  // Pause before a register write: covers a bin read in flight and a full clearing pass.
  localparam int SETTLE_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    op_t                  op;
    logic [ANGLE_W-1:0]   angle;
    logic [DIST_Q2_W-1:0] dist_q2;
    logic [QUAL_W-1:0]    qual;
    logic [BIN_W-1:0]     rbin;
  } node_item_t;

  typedef struct {
    logic [BIN_W-1:0] bin;
    logic [AVG_W-1:0] avg;
    logic             ok;
  } bin_avg_t;

  // One row of the directed table; a read row carries its typed-in answer.
  typedef struct {
    node_item_t       it;
    logic [AVG_W-1:0] avg;
    logic             ok;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  lidar_angle_bin_averager_unit #(
    .DISTANCE_BITS(DIST_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bin table model: per-bin committed sum and count, plus this scan's pending value.
  // ---------------------------------------------------------------------------
  logic [7:0]  qual_thr;
  logic [7:0]  scan_target;
  logic [7:0]  scans_seen;
  logic [31:0] bin_total [BIN_COUNT];
  logic [31:0] bin_hits  [BIN_COUNT];
  logic [31:0] pend_mm   [BIN_COUNT];
  logic        pend_ok   [BIN_COUNT];

  bin_avg_t avg_queue [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent = 0;
  int reads_checked = 0;
  int err_count = 0;
  int cycles = 0;
  int phases_run = 0;

  // Advance the model by one accepted transaction; return 1 when it yields a bin average.
  function automatic bit step_bin_table(input node_item_t it, output bin_avg_t res);
    logic [7:0]  needed;
    bit          complete;
    int          b;
    logic [31:0] mm;
    logic [63:0] quot;
    needed = (scan_target == 8'd0) ? 8'd1 : scan_target;
    complete = (scans_seen >= needed);
    res.bin = it.rbin;
    res.avg = '0;
    res.ok = 1'b0;
    case (it.op)
      OP_NODE: begin
        // Drop weak nodes; last qualifying node of a bin wins within a scan.
        if (!complete && it.qual >= qual_thr) begin
          b = (int'(it.angle) * ANGLE_MULT) >> ANGLE_SHIFT;
          mm = 32'(it.dist_q2) >> Q2_SHIFT;
          if (mm > (32'd1 << DIST_BITS) - 32'd1) mm = (32'd1 << DIST_BITS) - 32'd1;
          pend_mm[b] = mm;
          pend_ok[b] = 1'b1;
        end
        return 1'b0;
      end
      OP_END_SCAN: begin
        if (!complete) begin
          for (int i = 0; i < BIN_COUNT; i++) begin
            if (pend_ok[i]) begin
              bin_total[i] = bin_total[i] + pend_mm[i];
              bin_hits[i] = bin_hits[i] + 32'd1;
              pend_ok[i] = 1'b0;
            end
          end
          scans_seen = scans_seen + 8'd1;
        end
        return 1'b0;
      end
      OP_NEW_ROUND: begin
        for (int i = 0; i < BIN_COUNT; i++) begin
          bin_total[i] = '0;
          bin_hits[i] = '0;
          pend_mm[i] = '0;
          pend_ok[i] = 1'b0;
        end
        scans_seen = '0;
        return 1'b0;
      end
      default: begin
        // Bin read: out-of-range bins and empty or zero-sum bins answer invalid.
        if (int'(it.rbin) < BIN_COUNT) begin
          if (bin_hits[it.rbin] != 0 && bin_total[it.rbin] != 0) begin
            quot = {bin_total[it.rbin], 4'b0000} / 64'(bin_hits[it.rbin]);
            res.avg = (quot > 64'(AVG_MAX)) ? AVG_MAX : quot[AVG_W-1:0];
            res.ok = 1'b1;
          end
        end
        return 1'b1;
      end
    endcase
  endfunction

  function automatic node_item_t make_item(input op_t op, input logic [ANGLE_W-1:0] angle,
                                           input logic [DIST_Q2_W-1:0] dist_q2,
                                           input logic [QUAL_W-1:0] qual,
                                           input logic [BIN_W-1:0] rbin);
    node_item_t it;
    it.op = op;
    it.angle = angle;
    it.dist_q2 = dist_q2;
    it.qual = qual;
    it.rbin = rbin;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: optional idle gaps, then hold the transaction until it is taken.
  // ---------------------------------------------------------------------------
  task automatic push_item(input node_item_t it, input bit use_fixed = 1'b0,
                           input logic [AVG_W-1:0] fixed_avg = '0, input logic fixed_ok = 1'b0);
    bin_avg_t res;
    bit       has;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.op;
    in_tdata <= {5'b0, it.rbin, it.qual, it.dist_q2, it.angle};
    do @(posedge clk); while (!in_tready);
    has = step_bin_table(it, res);
    if (has) begin
      if (use_fixed) begin
        res.avg = fixed_avg;
        res.ok = fixed_ok;
      end
      avg_queue = {avg_queue, res};
    end
    sent++;
  endtask

  // Hold the input idle until every pending bin average has been returned.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (avg_queue.size() != 0) @(posedge clk);
  endtask

  // Register write with a setup phase and an access phase; the write lands at the access edge with pready high.
  task automatic cfg_write(input reg_idx_t idx, input logic [7:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'(int'(idx) * 4);
    cfg_pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_QUALITY) qual_thr = value;
    else scan_target = value;
  endtask

  // Drain, let the block settle, then load both registers and the idling mix.
  task automatic set_phase(input logic [7:0] thr, input logic [7:0] scans,
                           input int s_idle, input int r_stall);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write(REG_QUALITY, thr);
    cfg_write(REG_SCANS, scans);
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    phases_run++;
  endtask

  // Mostly well-formed rounds: ascending-angle nodes per scan, end of scan, reads of
  // touched bins. The rest is noise and rounds broken off mid-scan.
  task automatic run_random(input int budget);
    int                   start;
    int                   eff;
    int                   maxk;
    int                   n_scans;
    int                   k;
    int                   r;
    int                   angs [$];
    int                   touched [$];
    logic [DIST_Q2_W-1:0] dist_q2;
    logic [QUAL_W-1:0]    qual;
    logic [BIN_W-1:0]     rb;
    start = sent;
    while (sent - start < budget) begin
      if ($urandom_range(0, 99) < 12) begin
        push_item(make_item(op_t'($urandom_range(0, 3)), ANGLE_W'($urandom),
                            DIST_Q2_W'($urandom), QUAL_W'($urandom), BIN_W'($urandom)));
        continue;
      end
      eff = (scan_target == 8'd0) ? 1 : int'(scan_target);
      maxk = (eff > 8) ? 1 : 6;
      // Skip the new round now and then so a completed round sees ignored traffic.
      if ($urandom_range(0, 4) != 0)
        push_item(make_item(OP_NEW_ROUND, ANGLE_W'($urandom), DIST_Q2_W'($urandom),
                            QUAL_W'($urandom), BIN_W'($urandom)));
      touched.delete();
      n_scans = eff + $urandom_range(0, 1);
      for (int s = 0; s < n_scans && sent - start < budget; s++) begin
        k = $urandom_range(0, maxk);
        angs.delete();
        for (int j = 0; j < k; j++) begin
          r = $urandom_range(0, 99);
          angs = {angs, (r < 5 ? 0 : (r < 10 ? 65535 : int'($urandom_range(0, 65535))))};
        end
        angs.sort();
        foreach (angs[j]) begin
          r = $urandom_range(0, 99);
          if (r < 10) dist_q2 = '0;
          else if (r < 20) dist_q2 = '1;
          else if (r < 40) dist_q2 = DIST_Q2_W'($urandom_range(0, 1023));
          else dist_q2 = DIST_Q2_W'($urandom);
          if ($urandom_range(0, 1) == 0) qual = QUAL_W'($urandom_range(int'(qual_thr), 255));
          else qual = QUAL_W'($urandom);
          push_item(make_item(OP_NODE, ANGLE_W'(angs[j]), dist_q2, qual, BIN_W'($urandom)));
          touched = {touched, (angs[j] * ANGLE_MULT) >> ANGLE_SHIFT};
          if ($urandom_range(0, 99) < 8) begin
            rb = (touched.size() != 0 && $urandom_range(0, 9) < 6) ?
                 BIN_W'(touched[$urandom_range(0, touched.size() - 1)]) : BIN_W'($urandom);
            push_item(make_item(OP_READ, ANGLE_W'($urandom), DIST_Q2_W'($urandom),
                                QUAL_W'($urandom), rb));
          end
          // Break the round off in the middle of a scan.
          if ($urandom_range(0, 99) < 2)
            push_item(make_item(OP_NEW_ROUND, ANGLE_W'($urandom), DIST_Q2_W'($urandom),
                                QUAL_W'($urandom), BIN_W'($urandom)));
        end
        push_item(make_item(OP_END_SCAN, ANGLE_W'($urandom), DIST_Q2_W'($urandom),
                            QUAL_W'($urandom), BIN_W'($urandom)));
        repeat ($urandom_range(0, 2)) begin
          rb = (touched.size() != 0 && $urandom_range(0, 9) < 6) ?
               BIN_W'(touched[$urandom_range(0, touched.size() - 1)]) : BIN_W'($urandom);
          push_item(make_item(OP_READ, ANGLE_W'($urandom), DIST_Q2_W'($urandom),
                              QUAL_W'($urandom), rb));
        end
        if ($urandom_range(0, 99) < 3) wait_drained();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random backpressure and the field-by-field check.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    bin_avg_t want;
    if (rst_n && out_tvalid && out_tready) begin
      reads_checked++;
      if (avg_queue.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("[%0t] unexpected result: bin %0d avg %0d valid %0d", $realtime,
                   out_tdata[8:0], out_tdata[28:9], out_tuser);
      end else begin
        want = avg_queue.pop_front();
        if (out_tdata[8:0] !== want.bin || out_tdata[28:9] !== want.avg ||
            out_tuser !== want.ok) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("[%0t] mismatch: bin %0d/%0d avg %0d/%0d valid %0d/%0d (exp/act)",
                     $realtime, want.bin, out_tdata[8:0], want.avg, out_tdata[28:9],
                     want.ok, out_tuser);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, avg_queue.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [$];

  task automatic add_row(input op_t op, input int angle, input int dist_q2, input int qual,
                         input int rbin, input int avg = 0, input bit ok = 1'b0);
    dir_row_t row;
    row.it = make_item(op, ANGLE_W'(angle), DIST_Q2_W'(dist_q2), QUAL_W'(qual), BIN_W'(rbin));
    row.avg = AVG_W'(avg);
    row.ok = ok;
    dir_rows = {dir_rows, row};
  endtask

  initial begin
    bin_avg_t scratch;
    qual_thr = 8'(QUALITY_RESET);
    scan_target = 8'(SCANS_RESET);
    scans_seen = '0;
    void'(step_bin_table(make_item(OP_NEW_ROUND, '0, '0, '0, '0), scratch));

    // Reset values apply: threshold 60, one scan per round.
    add_row(OP_READ, 0, 0, 0, 0);                 // empty after reset
    add_row(OP_READ, 0, 0, 0, 359);
    add_row(OP_READ, 0, 0, 0, 511);               // bin out of range
    add_row(OP_READ, 0, 0, 0, 360);
    add_row(OP_NODE, 0, 262143, 255, 0);          // largest distance, 65535 mm
    add_row(OP_NODE, 65535, 400, 60, 0);          // top angle, quality at threshold
    add_row(OP_NODE, 16384, 4000, 59, 0);         // quality just below: dropped
    add_row(OP_READ, 0, 0, 0, 0);                 // pending values not yet committed
    add_row(OP_NODE, 0, 8, 200, 0);               // last node in bin 0 wins
    add_row(OP_END_SCAN, 0, 0, 0, 0);
    add_row(OP_READ, 0, 0, 0, 0, 32, 1'b1);
    add_row(OP_READ, 0, 0, 0, 359, 1600, 1'b1);
    add_row(OP_READ, 0, 0, 0, 90);
    add_row(OP_NODE, 16384, 4000, 100, 0);        // round complete: ignored
    add_row(OP_END_SCAN, 0, 0, 0, 0);             // round complete: ignored
    add_row(OP_READ, 0, 0, 0, 90);
    add_row(OP_NEW_ROUND, 0, 0, 0, 0);
    add_row(OP_READ, 0, 0, 0, 0);                 // new round empties the table
    add_row(OP_NODE, 182, 0, 255, 0);             // zero distance still counts
    add_row(OP_END_SCAN, 0, 0, 0, 0);
    add_row(OP_READ, 0, 0, 0, 0);                 // zero sum: invalid
    add_row(OP_NEW_ROUND, 0, 0, 0, 0);
    add_row(OP_NODE, 32768, 262143, 255, 0);
    add_row(OP_END_SCAN, 0, 0, 0, 0);
    add_row(OP_READ, 0, 0, 0, 180, 1048560, 1'b1); // largest average

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      push_item(dir_rows[i].it, dir_rows[i].it.op == OP_READ, dir_rows[i].avg, dir_rows[i].ok);

    // Random phases: threshold, scans per round, sender idle %, receiver stall %.
    set_phase(8'd0,   8'd1,   0,  0);  run_random(200);
    set_phase(8'd255, 8'd3,   48, 0);  run_random(200);
    set_phase(8'd128, 8'd0,   0,  48); run_random(200);  // zero scans acts as one
    set_phase(8'd30,  8'd4,   10, 10); run_random(200);
    set_phase(8'd200, 8'd255, 0,  0);  run_random(300);
    set_phase(8'd60,  8'd2,   10, 10); run_random(150);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (avg_queue.size() != 0) err_count++;

    $display("covered %0d transactions in %0d register phases, %0d bin reads checked",
             sent, phases_run, reads_checked);
    $display("thresholds 0..255, scans per round 0..255, idle and stall mixes applied");
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d errors", err_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
